// File: rtl/ctc_pkg.sv
package ctc_pkg;

  localparam int MaxRowKeysDef = 16;
  localparam int MaxColKeysDef = 16;
  localparam int CountBitsDef  = 32;

  localparam int KeyBits  = 64;
  localparam int SlotBits = 5;
  localparam int OutBits  = 32;

  typedef enum logic [1:0] {
    ST_COUNTED = 2'd0,
    ST_IGNORED = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture input beat
    logic lookup;   // register key match results
    logic rd;       // issue counter reads
    logic commit;   // write keys and counters, drive result
  } ctc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
  } ctc_stat_t;

  function automatic logic is_nan(input logic [KeyBits-1:0] v);
    return (v[62:52] == 11'h7ff) && (v[51:0] != '0);
  endfunction

  function automatic logic [KeyBits-1:0] norm_key(input logic [KeyBits-1:0] v);
    return (v == {1'b1, {(KeyBits-1){1'b0}}}) ? '0 : v;
  endfunction

endpackage

// File: rtl/ctc_ctrl.sv
module ctc_ctrl
  import ctc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  ctc_stat_t stat,
  output logic      busy,
  output ctc_cmd_t  cmd
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_LOOK, S_READ, S_COMMIT} state_t;
  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
    end else begin
      case (state)
        S_CLEAR: if (stat.clear_done) begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        S_IDLE: if (start) begin
          state <= S_LOOK;
          busy  <= 1'b1;
        end
        S_LOOK:   state <= S_READ;
        S_READ:   state <= S_COMMIT;
        S_COMMIT: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_comb begin
    cmd.load   = (state == S_IDLE) && start;
    cmd.lookup = (state == S_LOOK);
    cmd.rd     = (state == S_READ);
    cmd.commit = (state == S_COMMIT);
  end

  assert property (@(posedge clk) disable iff (rst) cmd.load |=> cmd.lookup)
    else $error("lookup did not follow load");
  assert property (@(posedge clk) disable iff (rst) cmd.commit |=> !busy)
    else $error("busy held after commit");
  assert property (@(posedge clk) disable iff (rst)
      $countones({cmd.load, cmd.lookup, cmd.rd, cmd.commit}) <= 1)
    else $error("overlapping commands");

endmodule

// File: rtl/ctc_dp.sv
module ctc_dp
  import ctc_pkg::*;
#(
  parameter int MAX_ROW_KEYS = MaxRowKeysDef,
  parameter int MAX_COL_KEYS = MaxColKeysDef,
  parameter int COUNT_BITS   = CountBitsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  ctc_cmd_t           cmd,
  output ctc_stat_t          stat,
  input  logic [KeyBits-1:0] x_value,
  input  logic               x_missing,
  input  logic [KeyBits-1:0] y_value,
  input  logic               y_missing,
  input  logic               x_column_numeric,
  input  logic               y_column_numeric,
  output logic               strobe,
  output logic [1:0]         status,
  output logic [SlotBits-1:0] row_slot,
  output logic [SlotBits-1:0] col_slot,
  output logic [OutBits-1:0] cell_total,
  output logic [OutBits-1:0] row_total,
  output logic [OutBits-1:0] col_total,
  output logic [OutBits-1:0] grand_total
);

  localparam int NRows = MAX_ROW_KEYS + 1;
  localparam int NCols = MAX_COL_KEYS + 1;
  localparam int NCells = NRows * NCols;
  localparam int RB = $clog2(NRows);
  localparam int CB = $clog2(NCols);
  localparam int RKB = (MAX_ROW_KEYS > 1) ? $clog2(MAX_ROW_KEYS) : 1;
  localparam int CKB = (MAX_COL_KEYS > 1) ? $clog2(MAX_COL_KEYS) : 1;
  localparam int CellB = $clog2(NCells);
  localparam int RUB = $clog2(MAX_ROW_KEYS + 1);
  localparam int CUB = $clog2(MAX_COL_KEYS + 1);
  localparam int ClrB = $clog2(NCells + 1);
  localparam logic [COUNT_BITS-1:0] CMax = '1;

  logic [KeyBits-1:0] row_keys [MAX_ROW_KEYS];
  logic [KeyBits-1:0] col_keys [MAX_COL_KEYS];
  logic [COUNT_BITS-1:0] cell_mem [NCells];
  logic [COUNT_BITS-1:0] row_mem [NRows];
  logic [COUNT_BITS-1:0] col_mem [NCols];
  logic [RUB-1:0] rows_used;
  logic [CUB-1:0] cols_used;
  logic [COUNT_BITS-1:0] pair_count;

  logic [KeyBits-1:0] xk, yk;
  logic xm, ym, ign;
  logic [RB-1:0] r;
  logic [CB-1:0] c;
  logic new_r, new_c, drop;
  logic [COUNT_BITS-1:0] cell_rd, row_rd, col_rd;
  logic [ClrB-1:0] clr;

  // key match, one compare per slot
  logic [RB-1:0] r_hit;
  logic r_found;
  logic [CB-1:0] c_hit;
  logic c_found;
  always_comb begin
    r_hit = RB'(rows_used);
    r_found = 1'b0;
    for (int i = MAX_ROW_KEYS - 1; i >= 0; i--) begin
      if (RUB'(i) < rows_used && row_keys[i] == xk) begin
        r_hit = RB'(i);
        r_found = 1'b1;
      end
    end
    c_hit = CB'(cols_used);
    c_found = 1'b0;
    for (int j = MAX_COL_KEYS - 1; j >= 0; j--) begin
      if (CUB'(j) < cols_used && col_keys[j] == yk) begin
        c_hit = CB'(j);
        c_found = 1'b1;
      end
    end
  end

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == CMax) ? v : v + 1'b1;
  endfunction

  logic [COUNT_BITS-1:0] cell_n, row_n, col_n, pair_n;
  logic [CellB-1:0] cidx;
  always_comb begin
    cell_n = sat_inc(cell_rd);
    row_n  = sat_inc(row_rd);
    col_n  = sat_inc(col_rd);
    pair_n = sat_inc(pair_count);
    cidx   = CellB'(r * NCols) + CellB'(c);
  end

  assign stat.clear_done = (clr == ClrB'(NCells));

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used  <= '0;
      cols_used  <= '0;
      pair_count <= '0;
      clr        <= '0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (!stat.clear_done) clr <= clr + 1'b1;
      if (cmd.commit && !ign && !drop) begin
        // a new key always lands below the table size
        if (new_r) begin
          row_keys[r[RKB-1:0]] <= xk;
          rows_used <= rows_used + 1'b1;
        end
        if (new_c) begin
          col_keys[c[CKB-1:0]] <= yk;
          cols_used <= cols_used + 1'b1;
        end
        pair_count <= pair_n;
      end
      if (cmd.commit) strobe <= 1'b1;
    end
  end

  // counter memories: clearing sweep, then read and write-back per beat
  always_ff @(posedge clk) begin
    if (!stat.clear_done) begin
      cell_mem[clr[CellB-1:0]] <= '0;
      if (clr < ClrB'(NRows)) row_mem[clr[RB-1:0]] <= '0;
      if (clr < ClrB'(NCols)) col_mem[clr[CB-1:0]] <= '0;
    end else if (cmd.commit && !ign && !drop) begin
      cell_mem[cidx] <= cell_n;
      row_mem[r]     <= row_n;
      col_mem[c]     <= col_n;
    end
    if (cmd.rd) begin
      cell_rd <= cell_mem[cidx];
      row_rd  <= row_mem[r];
      col_rd  <= col_mem[c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xk  <= norm_key(x_value);
      yk  <= norm_key(y_value);
      xm  <= x_missing;
      ym  <= y_missing;
      ign <= !x_column_numeric || !y_column_numeric || is_nan(x_value) || is_nan(y_value);
    end
    if (cmd.lookup) begin
      r <= xm ? RB'(MAX_ROW_KEYS) : r_hit;
      c <= ym ? CB'(MAX_COL_KEYS) : c_hit;
      new_r <= !xm && !r_found;
      new_c <= !ym && !c_found;
      drop  <= (!xm && !r_found && rows_used == RUB'(MAX_ROW_KEYS)) ||
               (!ym && !c_found && cols_used == CUB'(MAX_COL_KEYS));
    end
    if (cmd.commit) begin
      if (ign || drop) begin
        status      <= ign ? ST_IGNORED : ST_DROPPED;
        row_slot    <= '0;
        col_slot    <= '0;
        cell_total  <= '0;
        row_total   <= '0;
        col_total   <= '0;
        grand_total <= OutBits'(pair_count);
      end else begin
        status      <= ST_COUNTED;
        row_slot    <= SlotBits'(r);
        col_slot    <= SlotBits'(c);
        cell_total  <= OutBits'(cell_n);
        row_total   <= OutBits'(row_n);
        col_total   <= OutBits'(col_n);
        grand_total <= OutBits'(pair_n);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) rows_used <= RUB'(MAX_ROW_KEYS))
    else $error("row key count overflow");
  assert property (@(posedge clk) disable iff (rst) cols_used <= CUB'(MAX_COL_KEYS))
    else $error("column key count overflow");
  assert property (@(posedge clk) disable iff (rst)
      strobe && status == ST_COUNTED |-> cell_total != '0 && grand_total != '0)
    else $error("counted beat with zero count");

endmodule

// File: rtl/contingency_table_counter_unit.sv
// channel  | ports                                              | handshake
// input    | x_value x_missing y_value y_missing x/y_column_numeric | start && !busy
// result   | status row_slot col_slot *_total                   | strobe, one cycle
// Each pair passes through capture, key compare, counter read, write-back.
// busy stays high until write-back, so a new pair waits for the last one.
// After reset a clearing pass over all (MAX_ROW_KEYS+1)*(MAX_COL_KEYS+1) cells
// runs with busy high. The receiver cannot stall; strobe lasts one cycle.
module contingency_table_counter_unit
  import ctc_pkg::*;
#(
  parameter int MAX_ROW_KEYS = MaxRowKeysDef,
  parameter int MAX_COL_KEYS = MaxColKeysDef,
  parameter int COUNT_BITS   = CountBitsDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [KeyBits-1:0]  x_value,
  input  logic                x_missing,
  input  logic [KeyBits-1:0]  y_value,
  input  logic                y_missing,
  input  logic                x_column_numeric,
  input  logic                y_column_numeric,
  output logic                strobe,
  output logic [1:0]          status,
  output logic [SlotBits-1:0] row_slot,
  output logic [SlotBits-1:0] col_slot,
  output logic [OutBits-1:0]  cell_total,
  output logic [OutBits-1:0]  row_total,
  output logic [OutBits-1:0]  col_total,
  output logic [OutBits-1:0]  grand_total
);

  ctc_cmd_t  cmd;
  ctc_stat_t stat;

  ctc_ctrl u_ctrl (.clk, .rst, .start, .stat, .busy, .cmd);

  ctc_dp #(
    .MAX_ROW_KEYS(MAX_ROW_KEYS),
    .MAX_COL_KEYS(MAX_COL_KEYS),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk, .rst, .cmd, .stat, .x_value, .x_missing, .y_value, .y_missing,
    .x_column_numeric, .y_column_numeric, .strobe, .status, .row_slot,
    .col_slot, .cell_total, .row_total, .col_total, .grand_total
  );

endmodule

// File: bench/ctc_checker.sv
`timescale 1ns / 100ps

module ctc_checker
  import ctc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [KeyBits-1:0]  x_value,
  input  logic                x_missing,
  input  logic [KeyBits-1:0]  y_value,
  input  logic                y_missing,
  input  logic                x_column_numeric,
  input  logic                y_column_numeric,
  input  logic                strobe,
  input  logic [1:0]          status,
  input  logic [SlotBits-1:0] row_slot,
  input  logic [SlotBits-1:0] col_slot,
  input  logic [OutBits-1:0]  cell_total,
  input  logic [OutBits-1:0]  row_total,
  input  logic [OutBits-1:0]  col_total,
  input  logic [OutBits-1:0]  grand_total,
  output int                  errors,
  output int                  pending
);

  localparam int NR = MaxRowKeysDef;
  localparam int NC = MaxColKeysDef;
  localparam logic [OutBits-1:0] CMAX = '1;

  typedef struct packed {
    status_t            st;
    logic [SlotBits-1:0] r;
    logic [SlotBits-1:0] c;
    logic [OutBits-1:0] cnt;
    logic [OutBits-1:0] rsum;
    logic [OutBits-1:0] csum;
    logic [OutBits-1:0] grand;
  } tally_t;

  logic [KeyBits-1:0] rkey [NR];
  logic [KeyBits-1:0] ckey [NC];
  int nrows, ncols;
  logic [OutBits-1:0] cells [NR+1][NC+1];
  logic [OutBits-1:0] rtot [NR+1];
  logic [OutBits-1:0] ctot [NC+1];
  logic [OutBits-1:0] pairs;
  tally_t tally_q[$];

  function automatic logic nan_bits(logic [63:0] v);
    return v[62:52] == 11'h7ff && v[51:0] != 0;
  endfunction

  function automatic logic [OutBits-1:0] bump(logic [OutBits-1:0] v);
    return (v == CMAX) ? v : v + 1'b1;
  endfunction

  task automatic tally_pair(logic [63:0] xv, logic xm, logic [63:0] yv, logic ym,
                            logic xn, logic yn);
    tally_t t;
    int r, c;
    logic nr, nc;
    t = '0;
    t.st = ST_COUNTED;
    nr = 0; nc = 0; r = NR; c = NC;
    if (!xn || !yn || nan_bits(xv) || nan_bits(yv)) t.st = ST_IGNORED;
    else begin
      if (!xm) begin
        if (xv == 64'h8000_0000_0000_0000) xv = 0;
        r = nrows;
        for (int i = nrows - 1; i >= 0; i--) if (rkey[i] == xv) r = i;
        if (r == nrows) begin
          if (nrows >= NR) t.st = ST_DROPPED;
          else nr = 1;
        end
      end
      if (!ym) begin
        if (yv == 64'h8000_0000_0000_0000) yv = 0;
        c = ncols;
        for (int i = ncols - 1; i >= 0; i--) if (ckey[i] == yv) c = i;
        if (c == ncols) begin
          if (ncols >= NC) t.st = ST_DROPPED;
          else nc = 1;
        end
      end
    end
    if (t.st == ST_COUNTED) begin
      if (nr) begin rkey[nrows] = xv; nrows++; end
      if (nc) begin ckey[ncols] = yv; ncols++; end
      cells[r][c] = bump(cells[r][c]);
      rtot[r] = bump(rtot[r]);
      ctot[c] = bump(ctot[c]);
      pairs = bump(pairs);
      t.r = SlotBits'(r); t.c = SlotBits'(c);
      t.cnt = cells[r][c]; t.rsum = rtot[r]; t.csum = ctot[c];
    end
    t.grand = pairs;
    tally_q.push_back(t);
  endtask

  always @(posedge clk) begin
    tally_t e, a;
    if (rst) begin
      nrows = 0; ncols = 0; pairs = 0; errors = 0;
      foreach (cells[i, j]) cells[i][j] = 0;
      foreach (rtot[i]) rtot[i] = 0;
      foreach (ctot[i]) ctot[i] = 0;
      tally_q.delete();
    end else begin
      // result first: a beat accepted now cannot have its result this edge
      if (strobe) begin
        a = '{status_t'(status), row_slot, col_slot, cell_total, row_total,
              col_total, grand_total};
        if (tally_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, a);
        end else begin
          e = tally_q.pop_front();
          if (e != a) begin
            errors++;
            $display("%0t: mismatch expected st=%0d r=%0d c=%0d cnt=%0d row=%0d col=%0d grand=%0d",
                     $time, e.st, e.r, e.c, e.cnt, e.rsum, e.csum, e.grand);
            $display("%0t:          actual   st=%0d r=%0d c=%0d cnt=%0d row=%0d col=%0d grand=%0d",
                     $time, a.st, a.r, a.c, a.cnt, a.rsum, a.csum, a.grand);
          end
        end
      end
      if (start && !busy)
        tally_pair(x_value, x_missing, y_value, y_missing, x_column_numeric,
                   y_column_numeric);
    end
    pending = tally_q.size();
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import ctc_pkg::*;

  logic clk, rst, start, busy, strobe;
  logic [KeyBits-1:0] x_value, y_value;
  logic x_missing, y_missing, x_column_numeric, y_column_numeric;
  logic [1:0] status;
  logic [SlotBits-1:0] row_slot, col_slot;
  logic [OutBits-1:0] cell_total, row_total, col_total, grand_total;
  int errors, pending;
  int cycles = 0;
  int idle_pct = 0;
  int sent = 0;
  logic [63:0] xpool [24];
  logic [63:0] ypool [24];

  contingency_table_counter_unit dut (.*);
  ctc_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send(logic [63:0] xv, logic xm, logic [63:0] yv, logic ym,
                      logic xn, logic yn);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    x_value <= xv; x_missing <= xm; y_value <= yv; y_missing <= ym;
    x_column_numeric <= xn; y_column_numeric <= yn;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [63:0] any64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_pair();
    int k;
    logic [63:0] xv, yv;
    k = $urandom_range(99);
    xv = xpool[$urandom_range(23)];
    yv = ypool[$urandom_range(23)];
    if (k < 5) xv = any64();
    if (k >= 5 && k < 10) yv = any64();
    if (k >= 10 && k < 13) xv = {1'b0, 11'h7ff, 52'h1} | any64() & 64'h800f_ffff_ffff_ffff;
    if (k >= 13 && k < 16) yv = {any64() | 64'h7ff0_0000_0000_0001};
    send(xv, $urandom_range(9) == 0, yv, $urandom_range(9) == 0,
         $urandom_range(19) != 0, $urandom_range(19) != 0);
  endtask

  initial begin
    start = 0; rst = 1;
    x_value = 0; y_value = 0; x_missing = 0; y_missing = 0;
    x_column_numeric = 0; y_column_numeric = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // directed: zeros, signed zero, extremes, infinities, NaN, flags, NA
    send(64'h0, 0, 64'h0, 0, 1, 1);
    send(64'h8000_0000_0000_0000, 0, 64'h8000_0000_0000_0000, 0, 1, 1);
    send('1, 0, 64'h7fff_ffff_ffff_ffff, 0, 1, 1);
    send(64'h7ff0_0000_0000_0000, 0, 64'hfff0_0000_0000_0000, 0, 1, 1);
    send(64'h7ff8_0000_0000_0000, 0, 64'h0, 0, 1, 1);
    send(64'h0, 0, 64'hfff0_0000_0000_0001, 0, 1, 1);
    send(64'h7ff8_0000_0000_0000, 1, 64'h0, 0, 1, 1);
    send(64'h0, 0, 64'h0, 0, 0, 1);
    send(64'h0, 0, 64'h0, 0, 1, 0);
    send(64'h0, 1, 64'h0, 0, 1, 1);
    send(64'h0, 0, 64'h0, 1, 1, 1);
    send('1, 1, '1, 1, 1, 1);
    for (int i = 0; i < 15; i++) send(64'h100 + i, 0, 64'h0, 0, 1, 1);
    send(64'h5555, 0, 64'h0, 0, 1, 1);        // row table full
    for (int i = 0; i < 13; i++) send(64'h0, 0, 64'h200 + i, 0, 1, 1);
    send(64'h0, 0, 64'h6666, 0, 1, 1);        // fills the last column slot
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    // pools: table already full, so new keys mostly drop; mix known keys in
    for (int i = 0; i < 24; i++) begin
      xpool[i] = (i < 16) ? ((i < 2) ? 64'h0 : 64'h100 + i - 2) : any64();
      ypool[i] = (i < 16) ? ((i < 3) ? 64'h8000_0000_0000_0000 : 64'h200 + i - 3) : any64();
    end
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 29 : (ph == 1) ? 54 : 0;
      for (int n = 0; n < 550; n++) random_pair();
      start <= 0;
      while (pending != 0) @(posedge clk);
      @(negedge clk);
    end
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d pairs: signed zero, NaN, NA, non-numeric, full key tables", sent);
    $display("three idle profiles with a drain between each");
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
